// File: rtl/core/ncc_pkg.sv
// Shared types and constants for the normalized cross-correlation block.
// Used by the controller, the datapath, the multiplier and the top level.
package ncc_pkg;

    localparam int MAX_WINDOW_PIXELS = 65536;

    localparam int COUNT_W = 17;
    localparam int SUM_W   = 24;
    localparam int SQ_W    = 32;
    localparam int MUL_A_W = 128;
    localparam int MUL_B_W = 64;
    localparam int QUO_W   = 30;
    localparam int ROOT_W  = 15;
    localparam int STEP_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [2:0] MUL_V1 = 3'd0;
    localparam logic [2:0] MUL_V2 = 3'd1;
    localparam logic [2:0] MUL_P1 = 3'd2;
    localparam logic [2:0] MUL_P2 = 3'd3;
    localparam logic [2:0] MUL_A2 = 3'd4;
    localparam logic [2:0] MUL_T  = 3'd5;
    localparam logic [2:0] MUL_D  = 3'd6;

    typedef struct packed {
        logic       accept;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic       chk;
        logic       div_load;
        logic       div_test;
        logic       div_step;
        logic       sqrt_step;
        logic [3:0] sqrt_bit;
        logic       emit;
    } ncc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic degen;
        logic sat;
    } ncc_status_t;

endpackage

// File: rtl/core/ncc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are zero. Depends on ncc_pkg.
module ncc_mul
    import ncc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_A_W-1:0] product
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [MUL_A_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
        else if (go && !done_reg)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/core/ncc_dp.sv
// Datapath: window sums, product registers, restoring divider, bitwise
// square root and output payload. Depends on ncc_pkg and ncc_mul.
module ncc_dp
    import ncc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ncc_cmd_t           cmd,
    output ncc_status_t        status,
    input  logic [7:0]         scene_pixel,
    input  logic [7:0]         templ_pixel,
    output logic signed [15:0] correlation,
    output logic               degenerate
);

    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   ss_reg, st_reg;
    logic [SQ_W-1:0]    sss_reg, stt_reg, sts_reg;
    logic [48:0]        v1_reg, p1_reg;
    logic [47:0]        v2_reg, p2_reg;
    logic [65:0]        t_reg;
    logic [97:0]        d_reg;
    logic [MUL_A_W-1:0] a2_reg, dvs_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               deg_reg, sat_reg;
    logic [15:0]        corr_reg;
    logic               degenerate_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_A_W-1:0] mul_product;
    logic               neg;
    logic [48:0]        mag;
    logic [63:0]        a_val;
    logic [MUL_A_W-1:0] dvs_half;
    logic [ROOT_W-1:0]  trial;
    logic [QUO_W-1:0]   trial_sq;
    logic [15:0]        q16;
    logic [15:0]        corr_next;
    logic               grow;

    assign neg   = p1_reg < 49'(p2_reg);
    assign mag   = neg ? 49'(p2_reg) - p1_reg : p1_reg - 49'(p2_reg);
    assign a_val = {mag, 15'b0};

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_V1:
            begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = MUL_B_W'(sss_reg);
            end
            MUL_V2:
            begin
                mul_a = MUL_A_W'(ss_reg);
                mul_b = MUL_B_W'(ss_reg);
            end
            MUL_P1:
            begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = MUL_B_W'(sts_reg);
            end
            MUL_P2:
            begin
                mul_a = MUL_A_W'(ss_reg);
                mul_b = MUL_B_W'(st_reg);
            end
            MUL_A2:
            begin
                mul_a = MUL_A_W'(a_val);
                mul_b = a_val;
            end
            MUL_T:
            begin
                mul_a = MUL_A_W'(v1_reg - 49'(v2_reg));
                mul_b = MUL_B_W'(count_reg);
            end
            MUL_D:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(stt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ncc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (cmd.mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign grow = (32'(count_reg) < MAX_WINDOW_PIXELS) && (count_reg != COUNT_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ss_reg    <= '0;
            st_reg    <= '0;
            sss_reg   <= '0;
            stt_reg   <= '0;
            sts_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            ss_reg    <= '0;
            st_reg    <= '0;
            sss_reg   <= '0;
            stt_reg   <= '0;
            sts_reg   <= '0;
        end
        else if (cmd.accept && grow)
        begin
            count_reg <= count_reg + 1'b1;
            ss_reg    <= ss_reg + SUM_W'(scene_pixel);
            st_reg    <= st_reg + SUM_W'(templ_pixel);
            sss_reg   <= sss_reg + SQ_W'({8'b0, scene_pixel} * {8'b0, scene_pixel});
            stt_reg   <= stt_reg + SQ_W'({8'b0, templ_pixel} * {8'b0, templ_pixel});
            sts_reg   <= sts_reg + SQ_W'({8'b0, scene_pixel} * {8'b0, templ_pixel});
        end
    end

    assign dvs_half = dvs_reg >> 1;
    assign trial    = root_reg | (ROOT_W'(1) << cmd.sqrt_bit);
    assign trial_sq = trial * trial;

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (cmd.mul_sel)
                MUL_V1:  v1_reg <= mul_product[48:0];
                MUL_V2:  v2_reg <= mul_product[47:0];
                MUL_P1:  p1_reg <= mul_product[48:0];
                MUL_P2:  p2_reg <= mul_product[47:0];
                MUL_A2:  a2_reg <= mul_product;
                MUL_T:   t_reg  <= mul_product[65:0];
                MUL_D:   d_reg  <= mul_product[97:0];
                default: ;
            endcase
        end
        if (cmd.chk)
            deg_reg <= status.degen;
        if (cmd.div_load)
        begin
            dvs_reg  <= {d_reg, 30'b0};
            quo_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.div_test)
            sat_reg <= status.sat;
        if (cmd.div_step)
        begin
            dvs_reg <= dvs_half;
            if (a2_reg >= dvs_half)
            begin
                a2_reg  <= a2_reg - dvs_half;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
        end
        if (cmd.sqrt_step && trial_sq <= quo_reg)
            root_reg <= trial;
        if (cmd.emit)
        begin
            corr_reg       <= corr_next;
            degenerate_reg <= deg_reg;
        end
    end

    assign q16 = sat_reg ? 16'h8000 : {1'b0, root_reg};

    always_comb
    begin
        if (deg_reg)
            corr_next = '0;
        else if (neg)
            corr_next = 16'(17'h10000 - 17'(q16));
        else if (sat_reg)
            corr_next = 16'h7FFF;
        else
            corr_next = q16;
    end

    assign status.mul_done = mul_done;
    assign status.degen    = (count_reg == '0) || (stt_reg == '0) || (v1_reg <= 49'(v2_reg));
    assign status.sat      = a2_reg >= dvs_reg;

    assign correlation = $signed(corr_reg);
    assign degenerate  = degenerate_reg;

endmodule

// File: rtl/core/ncc_ctrl.sv
// Controller state machine: sequences accumulation, products, divide,
// square root and result hand-off. Depends on ncc_pkg.
module ncc_ctrl
    import ncc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic        last_pixel,
    output logic        result_valid,
    input  logic        result_ready,
    output ncc_cmd_t    cmd,
    input  ncc_status_t status
);

    localparam logic [3:0] ST_ACC  = 4'd0;
    localparam logic [3:0] ST_MV1  = 4'd1;
    localparam logic [3:0] ST_MV2  = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_MP1  = 4'd4;
    localparam logic [3:0] ST_MP2  = 4'd5;
    localparam logic [3:0] ST_MA2  = 4'd6;
    localparam logic [3:0] ST_MT   = 4'd7;
    localparam logic [3:0] ST_MD   = 4'd8;
    localparam logic [3:0] ST_DLD  = 4'd9;
    localparam logic [3:0] ST_DSAT = 4'd10;
    localparam logic [3:0] ST_DIV  = 4'd11;
    localparam logic [3:0] ST_SQRT = 4'd12;
    localparam logic [3:0] ST_EMIT = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic              accept;
    logic              slot_free;

    assign pixel_ready = (state_reg == ST_ACC);
    assign accept      = pixel_valid && pixel_ready;
    assign slot_free   = !valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.sqrt_bit  = cnt_reg[3:0];
        unique case (state_reg)
            ST_ACC:
                if (accept && last_pixel)
                    state_next = ST_MV1;
            ST_MV1:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_V1;
                if (status.mul_done)
                    state_next = ST_MV2;
            end
            ST_MV2:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_V2;
                if (status.mul_done)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = status.degen ? ST_EMIT : ST_MP1;
            end
            ST_MP1:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_P1;
                if (status.mul_done)
                    state_next = ST_MP2;
            end
            ST_MP2:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_P2;
                if (status.mul_done)
                    state_next = ST_MA2;
            end
            ST_MA2:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_A2;
                if (status.mul_done)
                    state_next = ST_MT;
            end
            ST_MT:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_T;
                if (status.mul_done)
                    state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_D;
                if (status.mul_done)
                    state_next = ST_DLD;
            end
            ST_DLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DSAT;
            end
            ST_DSAT:
            begin
                cmd.div_test = 1'b1;
                cnt_next     = STEP_W'(QUO_W - 1);
                state_next   = status.sat ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = STEP_W'(ROOT_W - 1);
                    state_next = ST_SQRT;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_EMIT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_EMIT:
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACC;
                end
            default:
                state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (result_ready)
            valid_next = 1'b0;
        if (cmd.emit)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

// File: rtl/core/normalized_cross_correlation.sv
// Top level of the normalized cross-correlation block: controller plus
// datapath. Depends on ncc_pkg, ncc_ctrl, ncc_dp.
//
//   channel | handshake                    | payload
//   pixel   | pixel_valid / pixel_ready    | scene_pixel, templ_pixel, last_pixel
//   result  | result_valid / result_ready  | correlation, degenerate
//
// A pixel beat that does not close a window is taken as soon as it is offered while accumulating.
// A closing beat starts a shared shift-add multiplier for seven products, a 30-step
// restoring divide and a 15-step square root; no pixel beat is taken then. A
// degenerate window ends after two products; saturation skips divide and root.
// The result register holds one beat; a stalled result blocks the next window's
// hand-off and pixel input while it waits. Reset clears all sums and control.
module normalized_cross_correlation
    import ncc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  logic [7:0]         scene_pixel,
    input  logic [7:0]         templ_pixel,
    input  logic               last_pixel,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [15:0] correlation,
    output logic               degenerate
);

    ncc_cmd_t    cmd;
    ncc_status_t status;

    ncc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .last_pixel   (last_pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    ncc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .scene_pixel (scene_pixel),
        .templ_pixel (templ_pixel),
        .correlation (correlation),
        .degenerate  (degenerate)
    );

endmodule

// File: verif/tb_normalized_cross_correlation.sv
`timescale 1ns / 1ps
// Testbench for normalized_cross_correlation: drives pixel-pair windows and
// checks each correlation beat against a built-in window model. Depends on ncc_pkg.
module tb_normalized_cross_correlation;
    import ncc_pkg::*;

    typedef struct packed {
        logic signed [15:0] corr;
        logic               degen;
    } corr_beat_t;

    logic               clk;
    logic               rst_n;
    logic               pixel_valid;
    logic               pixel_ready;
    logic [7:0]         scene_pixel;
    logic [7:0]         templ_pixel;
    logic               last_pixel;
    logic               result_valid;
    logic               result_ready;
    logic signed [15:0] correlation;
    logic               degenerate;

    normalized_cross_correlation dut (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .scene_pixel(scene_pixel), .templ_pixel(templ_pixel), .last_pixel(last_pixel),
        .result_valid(result_valid), .result_ready(result_ready),
        .correlation(correlation), .degenerate(degenerate)
    );

    logic [COUNT_W-1:0] win_count;
    logic [SUM_W-1:0]   win_s_sum;
    logic [SUM_W-1:0]   win_t_sum;
    logic [SQ_W-1:0]    win_ss_sum;
    logic [SQ_W-1:0]    win_tt_sum;
    logic [SQ_W-1:0]    win_st_sum;

    corr_beat_t expected_corr[$];
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    longint cycles;

    localparam longint CYCLE_LIMIT = 4000000;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic corr_beat_t close_window();
        corr_beat_t r;
        logic [63:0]  n, p1, p2, v1, v2, mag;
        logic [191:0] den, a2, lhs;
        logic [31:0]  lo, hi, mid;
        logic         neg;
        n   = win_count;
        p1  = n * win_st_sum;
        p2  = 64'(win_s_sum) * win_t_sum;
        v1  = n * win_ss_sum;
        v2  = 64'(win_s_sum) * win_s_sum;
        neg = p1 < p2;
        mag = neg ? p2 - p1 : p1 - p2;
        r.corr  = '0;
        r.degen = 1'b1;
        if (n != 0 && win_tt_sum != 0 && v1 > v2)
        begin
            den = 192'(v1 - v2) * 192'(n) * 192'(win_tt_sum);
            a2  = 192'(mag << 15) * 192'(mag << 15);
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                lhs = 192'(64'(mid) * mid) * den;
                if (lhs <= a2)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r.degen = 1'b0;
            if (neg)
                r.corr = 16'((32'h10000 - lo) & 32'hFFFF);
            else
                r.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
        end
        return r;
    endfunction

    task automatic clear_window();
        win_count  = '0;
        win_s_sum  = '0;
        win_t_sum  = '0;
        win_ss_sum = '0;
        win_tt_sum = '0;
        win_st_sum = '0;
    endtask

    task automatic accumulate_pixel(input logic [7:0] s, input logic [7:0] t, input logic last);
        if (win_count < MAX_WINDOW_PIXELS && win_count != COUNT_MAX)
        begin
            win_count  = win_count + 1'b1;
            win_s_sum  = win_s_sum + s;
            win_t_sum  = win_t_sum + t;
            win_ss_sum = win_ss_sum + 32'(s) * s;
            win_tt_sum = win_tt_sum + 32'(t) * t;
            win_st_sum = win_st_sum + 32'(s) * t;
        end
        if (last)
        begin
            expected_corr = {expected_corr, close_window()};
            clear_window();
        end
    endtask

    task automatic send_pixel(input logic [7:0] s, input logic [7:0] t, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        scene_pixel <= s;
        templ_pixel <= t;
        last_pixel  <= last;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        accumulate_pixel(s, t, last);
    endtask

    task automatic send_window(input int len, input int mode);
        logic [7:0] s, t, base;
        base = 8'($urandom);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: begin s = 8'($urandom); t = 8'($urandom); end
                1: begin s = 8'($urandom); t = s; end
                2: begin s = 8'($urandom); t = ~s; end
                3: begin s = base; t = 8'($urandom); end
                default: begin s = 8'($urandom); t = 8'd0; end
            endcase
            send_pixel(s, t, i == len - 1);
        end
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        while (expected_corr.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 1'b1);
        send_pixel(8'd10, 8'd10, 1'b0);
        send_pixel(8'd200, 8'd200, 1'b1);
        send_pixel(8'd10, 8'd200, 1'b0);
        send_pixel(8'd200, 8'd10, 1'b1);
        send_pixel(8'd7, 8'd0, 1'b0);
        send_pixel(8'd9, 8'd0, 1'b1);
        send_pixel(8'd5, 8'd3, 1'b0);
        send_pixel(8'd5, 8'd90, 1'b1);
        send_pixel(8'h55, 8'hAA, 1'b0);
        send_pixel(8'hAA, 8'h55, 1'b0);
        send_pixel(8'h0F, 8'hF0, 1'b1);
        drain();
    endtask

    task automatic test_random(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
            send_window(len, $urandom_range(5));
            sent += len;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        pixel_valid   = 1'b0;
        scene_pixel   = '0;
        templ_pixel   = '0;
        last_pixel    = 1'b0;
        result_ready  = 1'b0;
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clear_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 18;
        recv_idle_pct = 80;
        test_random(280);
        drain();
        send_idle_pct = 80;
        recv_idle_pct = 18;
        test_random(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(280);
        drain();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("tb_normalized_cross_correlation: done, clean");
        else
            $display("tb_normalized_cross_correlation: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        corr_beat_t exp_beat;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_corr.size() == 0)
            begin
                $display("%0t: unexpected beat corr=%0d degen=%0b",
                         $time, correlation, degenerate);
                errors++;
            end
            else
            begin
                exp_beat = expected_corr.pop_front();
                if (correlation !== exp_beat.corr)
                begin
                    $display("%0t: correlation expected %0d actual %0d",
                             $time, exp_beat.corr, correlation);
                    errors++;
                end
                if (degenerate !== exp_beat.degen)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, exp_beat.degen, degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_normalized_cross_correlation: done, errors");
            $finish;
        end
    end

    initial
        cycles = 0;

endmodule
